@@ hdl/sprj_pkg.sv @@
// Package: shared types and constants of the semantic point reprojection core
`default_nettype none
package sprj_pkg;

    // Pixel coordinate width and disparity fraction; the focal_baseline
    // register carries the same fraction, so it cancels in the division
    localparam int COORD_BITS     = 12;
    localparam int DISP_FRAC_BITS = 4;

    // Configuration register indexes
    localparam logic [2:0] REG_FOCAL_BASELINE = 3'd0;
    localparam logic [2:0] REG_INV_FOCAL_X    = 3'd1;
    localparam logic [2:0] REG_INV_FOCAL_Y    = 3'd2;
    localparam logic [2:0] REG_CENTER_X       = 3'd3;
    localparam logic [2:0] REG_CENTER_Y       = 3'd4;
    localparam logic [2:0] REG_MAX_RANGE      = 3'd5;
    localparam logic [2:0] REG_SAMPLE_STRIDE  = 3'd6;
    localparam logic [2:0] REG_MODE_FLAGS     = 3'd7;

    localparam int DIV_BITS = 32;
    localparam logic [31:0] HASH_MULT = 32'd2654435761;

    // One step of the restoring divider: remainder and quotient bits so far
    typedef struct packed {
        logic [15:0] rem;
        logic [31:0] quo;
    } div_step_t;

    // Fixed palette of the first twenty classes
    function automatic logic [23:0] palette(input logic [4:0] idx);
        logic [23:0] c;
        case (idx)
            5'd0:  c = {8'd0,   8'd150, 8'd255};
            5'd1:  c = {8'd230, 8'd25,  8'd75};
            5'd2:  c = {8'd60,  8'd180, 8'd75};
            5'd3:  c = {8'd255, 8'd225, 8'd25};
            5'd4:  c = {8'd245, 8'd130, 8'd48};
            5'd5:  c = {8'd145, 8'd30,  8'd180};
            5'd6:  c = {8'd70,  8'd240, 8'd240};
            5'd7:  c = {8'd240, 8'd50,  8'd230};
            5'd8:  c = {8'd210, 8'd245, 8'd60};
            5'd9:  c = {8'd250, 8'd190, 8'd212};
            5'd10: c = {8'd0,   8'd128, 8'd128};
            5'd11: c = {8'd220, 8'd190, 8'd255};
            5'd12: c = {8'd170, 8'd110, 8'd40};
            5'd13: c = {8'd255, 8'd250, 8'd200};
            5'd14: c = {8'd128, 8'd0,   8'd0};
            5'd15: c = {8'd170, 8'd255, 8'd195};
            5'd16: c = {8'd128, 8'd128, 8'd0};
            5'd17: c = {8'd255, 8'd215, 8'd180};
            5'd18: c = {8'd0,   8'd0,   8'd128};
            default: c = {8'd128, 8'd128, 8'd128};
        endcase
        return c;
    endfunction

    function automatic logic [7:0] lift_dark(input logic [7:0] x);
        return (x < 8'd50) ? x + 8'd100 : x;
    endfunction

endpackage
`default_nettype wire

@@ hdl/sprj_project.sv @@
// Coordinate projection pipeline: offset times depth times reciprocal focal length, rounded
`default_nettype none
module sprj_project #(
    parameter int COORD_BITS = 12
) (
    input  wire logic                  clk,
    input  wire logic                  en,
    input  wire logic [COORD_BITS-1:0] pos,
    input  wire logic [15:0]           center,
    input  wire logic [15:0]           depth,
    input  wire logic [24:0]           inv,
    output logic [31:0]                coord
);
    localparam int F = 16 - COORD_BITS;

    // Stage 1: offset magnitude and sign
    logic [16:0] off;
    logic        neg_reg;
    logic [15:0] mag_reg;
    logic [15:0] depth_reg;
    logic [24:0] inv_reg;
    // Stage 2: magnitude times depth
    logic        neg2_reg;
    logic [31:0] md_reg;
    logic [24:0] inv2_reg;
    // Stage 3: split product with inverse, low and high halves of md
    logic        neg3_reg;
    logic [40:0] plo_reg;
    logic [40:0] phi_reg;
    // Final stage: rounded result
    logic [56:0] prod;
    logic [56:0] rnd;
    logic [31:0] mag_out;

    assign off = {1'b0, pos, {F{1'b0}}} - {1'b0, center};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg_reg   <= off[16];
            mag_reg   <= off[16] ? 16'(-off) : off[15:0];
            depth_reg <= depth;
            inv_reg   <= inv;
            neg2_reg  <= neg_reg;
            md_reg    <= 32'(mag_reg) * 32'(depth_reg);
            inv2_reg  <= inv_reg;
            neg3_reg  <= neg2_reg;
            plo_reg   <= 41'(md_reg[15:0]) * 41'(inv2_reg);
            phi_reg   <= 41'(md_reg[31:16]) * 41'(inv2_reg);
            coord     <= neg3_reg ? 32'(-{1'b0, mag_out}) : mag_out;
        end
    end

    // Combine partial products and round half away from zero
    assign prod    = {phi_reg[40:0], 16'd0} + {16'd0, plo_reg};
    assign rnd     = prod + (57'd1 << (F + 23));
    assign mag_out = 32'(rnd >> (F + 24));
endmodule
`default_nettype wire

@@ hdl/semantic_point_reprojection_core.sv @@
// Top level: disparity pixel stream in, coloured labelled 3-D point stream out
`default_nettype none
// One pixel is taken per clock while the output is not stalled. A 12-stage
// stride test (one bit of column and row per stage), a 16-stage divider (two
// quotient bits per stage) that forms depth, a range check stage and a
// four-stage multiplier chain for X and Y follow one another. An output
// stall freezes the whole pipeline and holds s_tready low; pixels off the
// sampling stride or without a kept depth leave no point.
module semantic_point_reprojection_core (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_we,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [31:0]  cfg_data,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // column, row, disparity, color_a, color_b, color_c, class_label, label_confidence
    input  wire logic [111:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // point_x, point_y, point_z, packed_color, point_class, point_confidence
    output logic [151:0]      m_tdata
);
    localparam int COORD_BITS = sprj_pkg::COORD_BITS;
    localparam int NDIV = 16;
    localparam int NPRJ = 4;

    typedef struct packed {
        logic [COORD_BITS-1:0] u;
        logic [COORD_BITS-1:0] v;
        logic [23:0]           color;
        logic [31:0]           label;
        logic [15:0]           conf;
        logic                  dvalid;
        logic [15:0]           disp;
    } item_t;

    logic [31:0] focal_baseline_reg;
    logic [24:0] inv_focal_x_reg, inv_focal_y_reg;
    logic [15:0] center_x_reg, center_y_reg, max_range_reg;
    logic [4:0]  stride_reg;
    logic [1:0]  mode_reg;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            focal_baseline_reg <= '0;
            inv_focal_x_reg    <= '0;
            inv_focal_y_reg    <= '0;
            center_x_reg       <= '0;
            center_y_reg       <= '0;
            max_range_reg      <= 16'd10000;
            stride_reg         <= 5'd1;
            mode_reg           <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                sprj_pkg::REG_FOCAL_BASELINE: focal_baseline_reg <= cfg_data;
                sprj_pkg::REG_INV_FOCAL_X:    inv_focal_x_reg    <= cfg_data[24:0];
                sprj_pkg::REG_INV_FOCAL_Y:    inv_focal_y_reg    <= cfg_data[24:0];
                sprj_pkg::REG_CENTER_X:       center_x_reg       <= cfg_data[15:0];
                sprj_pkg::REG_CENTER_Y:       center_y_reg       <= cfg_data[15:0];
                sprj_pkg::REG_MAX_RANGE:      max_range_reg      <= cfg_data[15:0];
                sprj_pkg::REG_SAMPLE_STRIDE:  stride_reg         <= cfg_data[4:0];
                sprj_pkg::REG_MODE_FLAGS:     mode_reg           <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // Pipeline advances whenever output register is free or being drained
    logic adv;
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    // Stage 0: unpack the input transfer and flag a usable disparity
    item_t in_item;
    logic [15:0] din;
    assign din = s_tdata[39:24];
    always_comb
    begin
        in_item.u      = s_tdata[COORD_BITS-1:0];
        in_item.v      = s_tdata[12+COORD_BITS-1:12];
        in_item.disp   = din;
        in_item.color  = {s_tdata[47:40], s_tdata[55:48], s_tdata[63:56]};
        in_item.label  = s_tdata[95:64];
        in_item.conf   = s_tdata[111:96];
        in_item.dvalid = !din[15] && (din != 16'd0) && (focal_baseline_reg != 32'd0);
    end

    // Stride remainder: restoring modulo, with a zero stride treated as one
    logic [4:0]  stride_eff;
    assign stride_eff = (stride_reg == 5'd0) ? 5'd1 : stride_reg;

    // Stage A: register the stride test result
    logic   a_vld_reg;
    item_t  a_reg;
    // Stride test pipelined over COORD_BITS stages (one bit per stage, both coords)
    logic [COORD_BITS:0] sv_reg;
    item_t               sit_reg [COORD_BITS+1];
    logic [4:0]          ru_reg  [COORD_BITS+1];
    logic [4:0]          rv_reg  [COORD_BITS+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sv_reg <= '0;
        else if (adv)
            sv_reg <= {sv_reg[COORD_BITS-1:0], s_tvalid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sit_reg[0] <= in_item;
            ru_reg[0]  <= '0;
            rv_reg[0]  <= '0;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < COORD_BITS; gi++)
        begin : g_mod
            logic [5:0] tu, tv;
            assign tu = {ru_reg[gi], sit_reg[gi].u[COORD_BITS-1-gi]};
            assign tv = {rv_reg[gi], sit_reg[gi].v[COORD_BITS-1-gi]};
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    sit_reg[gi+1] <= sit_reg[gi];
                    ru_reg[gi+1]  <= (tu >= {1'b0, stride_eff}) ?
                                     5'(tu - {1'b0, stride_eff}) : tu[4:0];
                    rv_reg[gi+1]  <= (tv >= {1'b0, stride_eff}) ?
                                     5'(tv - {1'b0, stride_eff}) : tv[4:0];
                end
            end
        end
    endgenerate

    // Keep only pixels on the stride
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_vld_reg <= 1'b0;
        else if (adv)
            a_vld_reg <= sv_reg[COORD_BITS] && ru_reg[COORD_BITS] == '0
                         && rv_reg[COORD_BITS] == '0;
    end
    always_ff @(posedge clk)
    begin
        if (adv)
            a_reg <= sit_reg[COORD_BITS];
    end

    // Divider pipeline: two quotient bits per stage
    logic [NDIV:0] dv_reg;
    item_t         dit_reg [NDIV+1];
    sprj_pkg::div_step_t ds_reg [NDIV+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_reg <= '0;
        else if (adv)
            dv_reg <= {dv_reg[NDIV-1:0], a_vld_reg};
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dit_reg[0]    <= a_reg;
            ds_reg[0].rem <= '0;
            ds_reg[0].quo <= focal_baseline_reg;
        end
    end

    generate
        for (gi = 0; gi < NDIV; gi++)
        begin : g_div
            logic [16:0] r1, r2;
            logic [15:0] m1;
            logic        q1, q2;
            always_comb
            begin
                r1 = {ds_reg[gi].rem, ds_reg[gi].quo[31]};
                q1 = r1 >= {1'b0, dit_reg[gi].disp};
                m1 = q1 ? 16'(r1 - {1'b0, dit_reg[gi].disp}) : r1[15:0];
                r2 = {m1, ds_reg[gi].quo[30]};
                q2 = r2 >= {1'b0, dit_reg[gi].disp};
            end
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    dit_reg[gi+1]     <= dit_reg[gi];
                    ds_reg[gi+1].rem  <= q2 ? 16'(r2 - {1'b0, dit_reg[gi].disp}) : r2[15:0];
                    ds_reg[gi+1].quo  <= {ds_reg[gi].quo[29:0], q1, q2};
                end
            end
        end
    endgenerate

    // Range check and depth selection
    item_t  z_it_reg;
    logic   z_vld_reg;
    logic [15:0] z_reg;
    logic   beyond, keep;
    logic [15:0] z_sel;
    always_comb
    begin
        beyond = ds_reg[NDIV].quo > {16'd0, max_range_reg};
        keep   = mode_reg[0] || (dit_reg[NDIV].dvalid && !beyond);
        z_sel  = (dit_reg[NDIV].dvalid && !beyond) ? ds_reg[NDIV].quo[15:0] : max_range_reg;
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            z_vld_reg <= 1'b0;
        else if (adv)
            z_vld_reg <= dv_reg[NDIV] && keep;
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            z_it_reg <= dit_reg[NDIV];
            z_reg    <= z_sel;
        end
    end

    // Projection of both axes
    logic [31:0] px, py;
    sprj_project #(.COORD_BITS(COORD_BITS)) u_prj_x (
        .clk(clk), .en(adv), .pos(z_it_reg.u), .center(center_x_reg),
        .depth(z_reg), .inv(inv_focal_x_reg), .coord(px)
    );
    sprj_project #(.COORD_BITS(COORD_BITS)) u_prj_y (
        .clk(clk), .en(adv), .pos(z_it_reg.v), .center(center_y_reg),
        .depth(z_reg), .inv(inv_focal_y_reg), .coord(py)
    );

    // Side pipeline matching the projection latency; colour made at the end
    logic [NPRJ-1:0] pv_reg;
    item_t           pit_reg [NPRJ];
    logic [15:0]     pz_reg  [NPRJ];
    logic [31:0]     hash_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pv_reg <= '0;
        else if (adv)
            pv_reg <= {pv_reg[NPRJ-2:0], z_vld_reg};
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pit_reg[0] <= z_it_reg;
            pz_reg[0]  <= z_reg;
            for (int i = 1; i < NPRJ; i++)
            begin
                pit_reg[i] <= pit_reg[i-1];
                pz_reg[i]  <= pz_reg[i-1];
            end
            hash_reg <= pit_reg[NPRJ-2].label * sprj_pkg::HASH_MULT;
        end
    end

    logic [31:0] lab;
    logic [23:0] cls_color, color_out;
    always_comb
    begin
        lab = pit_reg[NPRJ-1].label;
        if (lab[31])
            cls_color = {8'd128, 8'd128, 8'd128};
        else if (lab < 32'd20)
            cls_color = sprj_pkg::palette(lab[4:0]);
        else
            cls_color = {sprj_pkg::lift_dark(hash_reg[23:16]),
                         sprj_pkg::lift_dark(hash_reg[15:8]),
                         sprj_pkg::lift_dark(hash_reg[7:0])};
        color_out = mode_reg[1] ? cls_color : pit_reg[NPRJ-1].color;
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid <= 1'b0;
        else if (adv)
            m_tvalid <= pv_reg[NPRJ-1];
    end
    always_ff @(posedge clk)
    begin
        if (adv)
            m_tdata <= {pit_reg[NPRJ-1].conf, lab, color_out,
                        pz_reg[NPRJ-1], py, px};
    end
endmodule
`default_nettype wire
